// ===== src/hrhp_pkg.sv =====
// shared types, constants and character tables for the http request header parser
// no dependencies; imported by the step logic and the top level
package hrhp_pkg;

    localparam int LEN_W       = 32;
    localparam int CL_OUT_W    = 32;
    localparam int POS_W       = 4;
    localparam int NUM_METH    = 5;
    localparam int VERSION_LEN = 8;
    localparam int CL_NAME_LEN = 14;
    localparam int OUT_DATA_W  = 48;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [2:0] METH_UNSUP = 3'd5;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [63:0]  VERSION_TEXT = "HTTP/1.1";
    localparam logic [111:0] CL_NAME_TEXT = "Content-Length";

    typedef enum logic [1:0] {
        KIND_URI     = 2'd0,
        KIND_URI_END = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [7:0] {
        PH_METHOD  = 8'b0000_0001,
        PH_URI     = 8'b0000_0010,
        PH_VERSION = 8'b0000_0100,
        PH_TAIL    = 8'b0000_1000,
        PH_HNAME   = 8'b0001_0000,
        PH_HLEAD   = 8'b0010_0000,
        PH_HVALUE  = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [POS_W-1:0]     pos;
        logic [NUM_METH-1:0]  cand;
        logic                 vbad;
        logic                 nmatch;
        logic [LEN_W-1:0]     len;
        logic                 lfound;
        logic                 plf;
        logic [2:0]           mres;
    } t_state;

    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [7:0]          uri_byte;
        logic [2:0]          method_code;
        logic [CL_OUT_W-1:0] length_out;
        logic                length_seen;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:  PH_METHOD,
        pos:    '0,
        cand:   '1,
        vbad:   1'b0,
        nmatch: 1'b1,
        len:    '0,
        lfound: 1'b0,
        plf:    1'b0,
        mres:   METH_UNSUP
    };

    function automatic logic [POS_W-1:0] method_len(input int m);
        logic [POS_W-1:0] l;
        case (m)
            0:       l = POS_W'(3);
            1:       l = POS_W'(4);
            2:       l = POS_W'(3);
            3:       l = POS_W'(6);
            default: l = POS_W'(4);
        endcase
        return l;
    endfunction

    // method text is left-justified in six characters
    function automatic logic [7:0] meth_char(input int m, input logic [POS_W-1:0] p);
        logic [47:0] txt;
        logic [47:0] sh;
        case (m)
            0:       txt = {"GET", 24'h0};
            1:       txt = {"POST", 16'h0};
            2:       txt = {"PUT", 24'h0};
            3:       txt = "DELETE";
            default: txt = {"HEAD", 16'h0};
        endcase
        sh = (p < POS_W'(6)) ? (txt >> (8 * (5 - int'(p)))) : '0;
        return sh[7:0];
    endfunction

    function automatic logic [7:0] version_char(input logic [POS_W-1:0] p);
        logic [63:0] sh;
        sh = (p < POS_W'(VERSION_LEN)) ?
             (VERSION_TEXT >> (8 * (VERSION_LEN - 1 - int'(p)))) : '0;
        return sh[7:0];
    endfunction

    function automatic logic [7:0] cl_char(input logic [POS_W-1:0] p);
        logic [111:0] sh;
        sh = (p < POS_W'(CL_NAME_LEN)) ?
             (CL_NAME_TEXT >> (8 * (CL_NAME_LEN - 1 - int'(p)))) : '0;
        return sh[7:0];
    endfunction

endpackage

// ===== src/hrhp_step.sv =====
// per-byte parser update: next state and the optional result word for one byte
// depends on hrhp_pkg
module hrhp_step (
    input  hrhp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    output hrhp_pkg::t_state  o_state,
    output hrhp_pkg::t_result o_result
);
    import hrhp_pkg::*;

    t_state             s;
    t_state             n;
    t_result            res;
    logic [LEN_W+3:0]   wide;
    logic [LEN_W+31:0]  len_ext;
    logic               is_digit;

    function automatic t_state start_line(input t_state st);
        t_state r;
        r        = st;
        r.phase  = PH_HNAME;
        r.pos    = '0;
        r.nmatch = 1'b1;
        r.plf    = 1'b1;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
        return (p == POS_MAX) ? p : p + POS_W'(1);
    endfunction

    assign s        = i_start ? STATE_RESET : i_state;
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    // value*10 + digit with four guard bits for the saturation test
    assign wide     = ({4'b0, s.len} << 3) + ({4'b0, s.len} << 1)
                    + {{LEN_W{1'b0}}, i_byte[3:0]};
    assign len_ext  = {32'b0, s.len};

    always_comb begin
        n   = s;
        res = '0;
        res.kind = KIND_URI;
        unique case (s.phase) inside
            PH_METHOD: begin
                if (i_byte == CH_SP) begin
                    n.mres = METH_UNSUP;
                    // lowest surviving candidate wins
                    for (int i = NUM_METH - 1; i >= 0; i--) begin
                        if (s.cand[i] && s.pos >= method_len(i)) begin
                            n.mres = 3'(i);
                        end
                    end
                    n.phase = PH_URI;
                    n.pos   = '0;
                end else begin
                    for (int i = 0; i < NUM_METH; i++) begin
                        if (s.pos < method_len(i) && i_byte != meth_char(i, s.pos)) begin
                            n.cand[i] = 1'b0;
                        end
                    end
                    n.pos = bump(s.pos);
                end
            end
            PH_URI: begin
                res.valid = 1'b1;
                if (i_byte == CH_SP) begin
                    n.phase  = PH_VERSION;
                    n.pos    = '0;
                    n.vbad   = 1'b0;
                    res.kind = KIND_URI_END;
                end else begin
                    res.uri_byte = i_byte;
                end
            end
            PH_VERSION: begin
                if (i_byte == CH_CR || i_byte == CH_LF) begin
                    if (s.vbad || s.pos != POS_W'(VERSION_LEN)) begin
                        n.mres = METH_UNSUP;
                    end
                    if (i_byte == CH_LF) begin
                        n = start_line(n);
                    end else begin
                        n.phase = PH_TAIL;
                    end
                end else begin
                    if (s.pos >= POS_W'(VERSION_LEN) || i_byte != version_char(s.pos)) begin
                        n.vbad = 1'b1;
                    end
                    n.pos = bump(s.pos);
                end
            end
            PH_TAIL: begin
                if (i_byte == CH_LF) begin
                    n = start_line(s);
                end
            end
            PH_HNAME: begin
                if (i_byte == CH_LF) begin
                    if (s.plf) begin
                        n.phase         = PH_DONE;
                        res.valid       = 1'b1;
                        res.kind        = KIND_SUMMARY;
                        res.method_code = s.mres;
                        res.length_out  = len_ext[CL_OUT_W-1:0];
                        res.length_seen = s.lfound;
                    end else begin
                        n = start_line(s);
                    end
                end else if (i_byte == CH_CR) begin
                    if (!s.plf) begin
                        n.phase = PH_TAIL;
                    end
                end else begin
                    n.plf = 1'b0;
                    if (i_byte == CH_COLON || i_byte == CH_SP) begin
                        if (s.nmatch && s.pos == POS_W'(CL_NAME_LEN) && !s.lfound) begin
                            n.lfound = 1'b1;
                            n.len    = '0;
                            n.phase  = PH_HLEAD;
                        end else begin
                            n.phase = PH_TAIL;
                        end
                    end else begin
                        if (s.pos >= POS_W'(CL_NAME_LEN) || i_byte != cl_char(s.pos)) begin
                            n.nmatch = 1'b0;
                        end
                        n.pos = bump(s.pos);
                    end
                end
            end
            PH_HLEAD, PH_HVALUE: begin
                if (i_byte == CH_LF) begin
                    n = start_line(s);
                end else if (i_byte == CH_SP && s.phase == PH_HLEAD) begin
                    n = s;
                end else if (is_digit) begin
                    n.len   = (|wide[LEN_W+3:LEN_W]) ? '1 : wide[LEN_W-1:0];
                    n.phase = PH_HVALUE;
                end else begin
                    n.phase = PH_TAIL;
                end
            end
            PH_DONE: begin
                n = s;
            end
            default: begin
                n = s;
            end
        endcase
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

// ===== src/http_request_header_parser.sv =====
// http request header parser: takes one request byte per word and gives uri bytes,
// a uri end marker and at most one header summary per request. Throughput is one byte per
// clock; a result word is registered first in the input register, then in the result
// register. Back pressure on the result side holds the pipeline, while the input register
// still takes a word if it is empty.
// depends on hrhp_pkg and hrhp_step
module http_request_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic [0:0]  s_axis_tuser,  // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // uri_byte[7:0], method_code[10:8], length value[42:11], length_seen[43], zero fill
    output logic [hrhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser   // out_kind
);
    import hrhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic       adv;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;

    hrhp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && n_result.valid;
            end
            if (r_in_valid && adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
        if (adv && r_in_valid) begin
            r_out_kind <= n_result.kind;
            r_out_data <= {4'b0, n_result.length_seen, n_result.length_out,
                           n_result.method_code, n_result.uri_byte};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

endmodule

// ===== src/hrhp_checker.sv =====
// port-level checks for the http request header parser, attached by bind
// depends on hrhp_pkg and the top level's ports
module hrhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    // uri_byte[7:0], method_code[10:8], length value[42:11], length_seen[43], zero fill
    input logic [hrhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser   // out_kind
);
    import hrhp_pkg::*;

    // nothing is shown in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back pressure");

    // the byte after the ending empty line can never produce a word
    a_summary_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_SUMMARY)
        |=> !m_axis_tvalid)
        else $error("result word directly after a header summary");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result word changed");

endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (.*);

// ===== verif/tb_http_request_header_parser.sv =====
`timescale 1ns / 100ps
// self-checking testbench for http_request_header_parser: directed requests, then random ones
// predicts result words from its own parser model or a hand-typed summary, compares field by field
// depends on hrhp_pkg and the parser rtl
module tb_http_request_header_parser;
    import hrhp_pkg::*;

    typedef enum logic [2:0] {
        METHOD_GET    = 3'd0,
        METHOD_POST   = 3'd1,
        METHOD_PUT    = 3'd2,
        METHOD_DELETE = 3'd3,
        METHOD_HEAD   = 3'd4,
        METHOD_UNSUP  = 3'd5
    } t_method;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  uri;
        t_method     meth;
        logic [31:0] clen;
        logic        seen;
    } t_word;

    typedef struct {
        string       text;
        bit          typed;
        t_method     meth;
        logic [31:0] clen;
        logic        seen;
    } t_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // data_byte
    logic [0:0]  s_axis_tuser = '0;   // start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // uri_byte[7:0], method_code[10:8], length value[42:11], length_seen[43], zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;        // out_kind

    http_request_header_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    string meth_name [5] = '{"GET", "POST", "PUT", "DELETE", "HEAD"};
    string vers_text = "HTTP/1.1";
    string cl_text   = "Content-Length";

    // parser model state
    t_phase      st_phase;
    logic [3:0]  st_pos;
    logic [4:0]  st_cand;
    logic        st_vbad;
    logic        st_nmatch;
    logic [31:0] st_len;
    logic        st_lfound;
    logic        st_plf;
    t_method     st_method;

    t_word       due_words [$];
    logic [7:0]  req_bytes [$];

    int tx_gap_pct = 13;
    int rx_gap_pct = 48;
    int bytes_sent = 0;
    int requests   = 0;
    int bad_count  = 0;
    int uri_words  = 0;
    int end_words  = 0;
    int sum_words  = 0;

    // directed rows may carry a summary typed in by hand
    bit          typed_on = 1'b0;
    t_method     typed_meth;
    logic [31:0] typed_len;
    logic        typed_seen;

    t_case cases [18] = '{
        '{"GET / HTTP/1.1\r\n\r\n", 1, METHOD_GET, 32'd0, 1'b0},
        '{"POST /up HTTP/1.1\r\nContent-Length: 42\r\n\r\n", 1, METHOD_POST, 32'd42, 1'b1},
        '{"PUT /f HTTP/1.1\n\n", 1, METHOD_PUT, 32'd0, 1'b0},
        '{"DELETE /\377 HTTP/1.1\r\n\r\n", 1, METHOD_DELETE, 32'd0, 1'b0},
        '{"HEAD / HTTP/1.1\r\nContent-Length:4294967295\r\n\r\n", 1, METHOD_HEAD,
          32'hffff_ffff, 1'b1},
        '{"GE / HTTP/1.1\r\n\r\n", 1, METHOD_UNSUP, 32'd0, 1'b0},
        '{"GETS / HTTP/1.1\r\n\r\n", 1, METHOD_GET, 32'd0, 1'b0},
        '{"GET / HTTP/1.1\r\n\r\n", 1, METHOD_GET, 32'd0, 1'b0},
        '{"PUT / HTTP/1.11\r\n\r\n", 1, METHOD_UNSUP, 32'd0, 1'b0},
        '{"GET / HTTP/1.1\r\nContent-Length: 99999999999\r\n\r\n", 1, METHOD_GET,
          32'hffff_ffff, 1'b1},
        '{"GET / HTTP/1.1\r\nContent-Length: 7\r\nContent-Length: 9\r\n\r\n", 1,
          METHOD_GET, 32'd7, 1'b1},
        '{"GET / HTTP/1.1\r\nContent-Length: -5\r\n\r\n", 1, METHOD_GET, 32'd0, 1'b1},
        '{"GET / HTTP/1.1\r\ncontent-length: 5\r\nHost\r\n: 3\r\n\r\r\n", 1,
          METHOD_GET, 32'd0, 1'b0},
        '{"G\nT /a\nb HTTP/1.1\n\n", 1, METHOD_UNSUP, 32'd0, 1'b0},
        '{"POST /x HTTP/1.1\nContent-Length:12ab\n\nzz", 1, METHOD_POST, 32'd12, 1'b1},
        '{"PUT /abc", 0, METHOD_UNSUP, 32'd0, 1'b0},
        '{"HEAD /h HTTP/1.1\r\nX\rContent-Length: 5\r\n\r\n", 0, METHOD_UNSUP,
          32'd0, 1'b0},
        '{"GET / HTTP/1.1\nContent-Length:   \n\n", 1, METHOD_GET, 32'd0, 1'b1}
    };

    function automatic void clear_parser();
        st_phase  = PH_METHOD;
        st_pos    = '0;
        st_cand   = '1;
        st_vbad   = 1'b0;
        st_nmatch = 1'b1;
        st_len    = '0;
        st_lfound = 1'b0;
        st_plf    = 1'b0;
        st_method = METHOD_UNSUP;
    endfunction

    function automatic void bump_pos();
        if (st_pos != POS_MAX) st_pos = st_pos + 1'b1;
    endfunction

    function automatic void begin_line();
        st_phase  = PH_HNAME;
        st_pos    = '0;
        st_nmatch = 1'b1;
        st_plf    = 1'b1;
    endfunction

    // one request byte through the parser; made is set when a word comes out
    function automatic void parse_byte(input logic [7:0] b, input logic first,
                                       output logic made, output t_word w);
        int          i;
        logic [63:0] acc;
        made = 1'b0;
        w = '0;
        if (first) clear_parser();
        case (st_phase) inside
            PH_METHOD: begin
                if (b == CH_SP) begin
                    st_method = METHOD_UNSUP;
                    // walk down so the lowest matching code wins
                    for (i = 4; i >= 0; i--)
                        if (st_cand[i] && st_pos >= meth_name[i].len())
                            st_method = t_method'(i);
                    st_phase = PH_URI;
                    st_pos = '0;
                end else begin
                    for (i = 0; i < 5; i++)
                        if (st_pos < meth_name[i].len() && b != meth_name[i][st_pos])
                            st_cand[i] = 1'b0;
                    bump_pos();
                end
            end
            PH_URI: begin
                made = 1'b1;
                if (b == CH_SP) begin
                    st_phase = PH_VERSION;
                    st_pos = '0;
                    st_vbad = 1'b0;
                    w.kind = KIND_URI_END;
                end else begin
                    w.kind = KIND_URI;
                    w.uri = b;
                end
            end
            PH_VERSION: begin
                if (b == CH_CR || b == CH_LF) begin
                    if (st_vbad || st_pos != vers_text.len()) st_method = METHOD_UNSUP;
                    if (b == CH_LF) begin_line();
                    else st_phase = PH_TAIL;
                end else begin
                    if (st_pos >= vers_text.len() || b != vers_text[st_pos]) st_vbad = 1'b1;
                    bump_pos();
                end
            end
            PH_TAIL: begin
                if (b == CH_LF) begin_line();
            end
            PH_HNAME: begin
                if (b == CH_LF) begin
                    if (st_plf) begin
                        st_phase = PH_DONE;
                        made = 1'b1;
                        w.kind = KIND_SUMMARY;
                        w.meth = st_method;
                        w.clen = st_len;
                        w.seen = st_lfound;
                    end else begin
                        begin_line();
                    end
                end else if (b == CH_CR) begin
                    if (!st_plf) st_phase = PH_TAIL;
                end else begin
                    st_plf = 1'b0;
                    if (b == CH_COLON || b == CH_SP) begin
                        if (st_nmatch && st_pos == cl_text.len() && !st_lfound) begin
                            st_lfound = 1'b1;
                            st_len = '0;
                            st_phase = PH_HLEAD;
                        end else begin
                            st_phase = PH_TAIL;
                        end
                    end else begin
                        if (st_pos >= cl_text.len() || b != cl_text[st_pos])
                            st_nmatch = 1'b0;
                        bump_pos();
                    end
                end
            end
            PH_HLEAD, PH_HVALUE: begin
                if (b == CH_LF) begin
                    begin_line();
                end else if (b == CH_SP && st_phase == PH_HLEAD) begin
                    // leading space, skipped
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    acc = 64'(st_len) * 10 + 64'(b - CH_ZERO);
                    st_len = (acc > 64'hffff_ffff) ? 32'hffff_ffff : acc[31:0];
                    st_phase = PH_HVALUE;
                end else begin
                    st_phase = PH_TAIL;
                end
            end
            default: ;
        endcase
    endfunction

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= rx_gap_pct);

    always @(posedge i_clk) begin : check_blk
        t_word pred;
        t_word got;
        t_word want;
        logic  made;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            parse_byte(s_axis_tdata, s_axis_tuser[0], made, pred);
            if (made) begin
                if (typed_on && pred.kind == KIND_SUMMARY) begin
                    pred.meth = typed_meth;
                    pred.clen = typed_len;
                    pred.seen = typed_seen;
                end
                due_words.push_back(pred);
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = t_kind'(m_axis_tuser);
            got.uri  = m_axis_tdata[7:0];
            got.meth = t_method'(m_axis_tdata[10:8]);
            got.clen = m_axis_tdata[42:11];
            got.seen = m_axis_tdata[43];
            case (got.kind)
                KIND_URI:     uri_words++;
                KIND_URI_END: end_words++;
                default:      sum_words++;
            endcase
            if (due_words.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: word with nothing expected: kind %0d uri %02h", $realtime,
                             got.kind, got.uri);
            end else begin
                want = due_words.pop_front();
                if (got.kind !== want.kind || got.uri !== want.uri ||
                    got.meth !== want.meth || got.clen !== want.clen ||
                    got.seen !== want.seen) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display({"%0t: expected kind %0d uri %02h method %0d length %0d ",
                                  "seen %0d, got kind %0d uri %02h method %0d length %0d ",
                                  "seen %0d"}, $realtime,
                                 want.kind, want.uri, want.meth, want.clen, want.seen,
                                 got.kind, got.uri, got.meth, got.clen, got.seen);
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = first;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        int i;
        requests++;
        for (i = 0; i < s.len(); i++) push_byte(s[i], i == 0);
    endtask

    task automatic send_built();
        int i;
        requests++;
        for (i = 0; i < req_bytes.size(); i++) push_byte(req_bytes[i], i == 0);
    endtask

    // sender holds off until every predicted word has come out
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (due_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
    endfunction

    function automatic void add_caps(input int n);
        int i;
        for (i = 0; i < n; i++) req_bytes.push_back(8'h41 + 8'($urandom_range(25)));
    endfunction

    function automatic void add_digits(input int n);
        int i;
        for (i = 0; i < n; i++) req_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void add_eol();
        if ($urandom_range(1)) add_text("\r\n");
        else add_text("\n");
    endfunction

    // mostly well-formed requests with random content, some noise and broken ones
    function automatic void build_request();
        int         i, k, n, nh, cut;
        logic [7:0] c;
        req_bytes.delete();
        if ($urandom_range(19) == 0) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++) req_bytes.push_back(8'($urandom));
            return;
        end
        k = $urandom_range(4);
        case ($urandom_range(9))
            0: add_caps($urandom_range(0, 7));
            1: add_text(meth_name[k].substr(0, $urandom_range(0, meth_name[k].len() - 2)));
            2: begin
                add_text(meth_name[k]);
                add_caps($urandom_range(1, 3));
            end
            3: begin
                add_text(meth_name[k].substr(0, 0));
                c = 8'($urandom);
                req_bytes.push_back((c == CH_SP) ? CH_LF : c);
                add_text(meth_name[k].substr(2, meth_name[k].len() - 1));
            end
            default: add_text(meth_name[k]);
        endcase
        req_bytes.push_back(CH_SP);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       c = $urandom_range(1) ? 8'h00 : 8'hff;
                1:       c = 8'($urandom);
                default: c = 8'h21 + 8'($urandom_range(93));
            endcase
            req_bytes.push_back((c == CH_SP) ? 8'h2f : c);
        end
        req_bytes.push_back(CH_SP);
        case ($urandom_range(11))
            0:       add_text("HTTP/1.0");
            1:       add_text("HTTP/1.");
            2:       add_text("HTTP/1.11");
            3:       add_text("http/1.1");
            4:       add_text("HTTP/1.1HTTP/1.1x");
            5:       ;
            6:       add_text("HTTP/1.1\rjunk");
            default: add_text("HTTP/1.1");
        endcase
        add_eol();
        nh = $urandom_range(0, 4);
        for (i = 0; i < nh; i++) begin
            case ($urandom_range(9))
                0: add_text("Host: example");
                1: add_text("content-length: 12");
                2: add_text("Content-Lengt: 5");
                3: add_text("Content-Lengthy: 5");
                4: add_text("X-Junk\r1");
                5: add_text(": 77");
                default: begin
                    add_text("Content-Length");
                    add_text(($urandom_range(3) == 0) ? " " : ":");
                    repeat ($urandom_range(0, 3)) req_bytes.push_back(CH_SP);
                    case ($urandom_range(7))
                        0:       add_text("4294967295");
                        1:       add_text("4294967296");
                        2:       add_text("-1");
                        3:       ;
                        default: add_digits($urandom_range(1, 12));
                    endcase
                    if ($urandom_range(4) == 0) add_text("z9");
                end
            endcase
            add_eol();
        end
        add_eol();
        if ($urandom_range(9) == 0) add_text("GET / x");
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, req_bytes.size() - 1);
            while (req_bytes.size() > cut) void'(req_bytes.pop_back());
        end
    endfunction

    task automatic run_random(input int tx_pct, input int rx_pct, input int count);
        int goal;
        tx_gap_pct = tx_pct;
        rx_gap_pct = rx_pct;
        goal = bytes_sent + count;
        while (bytes_sent < goal) begin
            build_request();
            send_built();
        end
        drain();
    endtask

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stim_blk
        int i;
        clear_parser();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (i = 0; i < 18; i++) begin
            typed_on   = cases[i].typed;
            typed_meth = cases[i].meth;
            typed_len  = cases[i].clen;
            typed_seen = cases[i].seen;
            send_text(cases[i].text);
        end
        drain();
        typed_on = 1'b0;

        run_random(13, 48, 450);
        run_random(48, 13, 450);
        run_random(0, 0, 450);
        repeat (10) @(negedge i_clk);

        $display("sent %0d bytes in %0d requests under three idle mixes", bytes_sent, requests);
        $display("checked %0d uri bytes, %0d uri ends and %0d header summaries",
                 uri_words, end_words, sum_words);
        if (bad_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d bad words", bad_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
